// File: rtl/minimum_window_cover_defines.svh
// Assertion macros for the minimum window cover block.
// Each one needs clk and rst_n in scope.
`ifndef MINIMUM_WINDOW_COVER_DEFINES_SVH
`define MINIMUM_WINDOW_COVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define MWC_ASSERT(lbl, prop, msg)
`define MWC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/mwc_pkg.sv
package mwc_pkg;

  localparam int MAX_TEXT    = 1024;
  localparam int MAX_PATTERN = 1024;
  localparam int ALPHABET    = 128;

  localparam int SYM_W   = 7;
  localparam int CNT_W   = 11;
  localparam int TPOS_W  = $clog2(MAX_TEXT + 1);
  localparam int TADDR_W = $clog2(MAX_TEXT);
  localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_UPD,
    ST_TXT_UPD,
    ST_CHECK,
    ST_OUT_SYM,
    ST_OUT_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] have;
  } cnt_pair_t;

  typedef struct packed {
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    cnt_pair_t        wr_data;
    logic             clear;
  } cnt_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [TADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic [TADDR_W-1:0] wr_addr;
    logic [SYM_W-1:0]   wr_data;
  } txt_req_t;

  typedef struct packed {
    logic              idle;
    logic [PLEN_W-1:0] plen;
    logic [PLEN_W-1:0] cov;
    logic [TPOS_W-1:0] wl;
    logic [TPOS_W-1:0] tpos;
  } stat_t;

endpackage

// File: rtl/mwc_ifs.sv
interface mwc_in_if import mwc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output mode, output symbol, output last, input ready);
  modport sink   (input valid, input mode, input symbol, input last, output ready);
endinterface

interface mwc_out_if import mwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] start_res;
  logic [LEN_W-1:0]   length;
  logic               overflow;

  modport source (output valid, output found, output start_res, output length,
                  output overflow, input ready);
  modport sink   (input valid, input found, input start_res, input length,
                  input overflow, output ready);
endinterface

// File: rtl/minimum_window_cover.sv
// Minimum window cover: send the pattern as mode-0 requests, then the text as
// mode-1 requests, one character each; the request with last set returns one
// result (found, start, length, overflow) and clears the block for the next
// job. Pattern requests after text are ignored; characters past 1024 are
// dropped and flagged. The block takes a new request only when idle, after it
// has finished with the last one; a text request also sheds characters from
// the window's left, and a request with last loads the result once the
// previous result has been taken. Each text character leaves the window at
// most once. The per-symbol count memory has a registered read, and the
// sequencer runs one read-modify-write on it at a time. No clearing pass
// after reset.
`include "minimum_window_cover_defines.svh"

module minimum_window_cover import mwc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mwc_in_if.sink    in_ch,
  mwc_out_if.source out_ch
);

  cnt_req_t         cnt_req;
  cnt_pair_t        cnt_rdata;
  txt_req_t         txt_req;
  logic [SYM_W-1:0] txt_rdata;
  stat_t            stat;

  mwc_count_mem u_count_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cnt_req),
    .rdata (cnt_rdata)
  );

  mwc_text_mem u_text_mem (
    .clk   (clk),
    .req   (txt_req),
    .rdata (txt_rdata)
  );

  mwc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cnt_req   (cnt_req),
    .cnt_rdata (cnt_rdata),
    .txt_req   (txt_req),
    .txt_rdata (txt_rdata),
    .stat      (stat)
  );

  `MWC_ASSERT(a_cov_le_plen, stat.cov <= stat.plen, "covered count exceeds pattern length")
  `MWC_ASSERT(a_wl_le_tpos, stat.wl <= stat.tpos, "window left passed text position")
  `MWC_ASSERT(a_nf_zero, out_ch.valid && !out_ch.found |-> out_ch.length == '0 && out_ch.start_res == '0, "not-found result not zeroed")
  `MWC_ASSERT_NEXT(a_last_clears, in_ch.valid && in_ch.ready && in_ch.last && !in_ch.mode && stat.tpos == '0 && stat.plen == '0, !stat.idle, "last request did not go to result")

endmodule

// File: rtl/mwc_count_mem.sv
module mwc_count_mem import mwc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cnt_req_t  req,
  output cnt_pair_t rdata
);

  cnt_pair_t           mem [ALPHABET];
  logic [ALPHABET-1:0] vld_r;
  cnt_pair_t           rdata_r;

  // per-entry valid bits let a job clear all entries at once, with no pass over the memory
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mwc_text_mem.sv
module mwc_text_mem import mwc_pkg::*; (
  input  logic             clk,
  input  txt_req_t         req,
  output logic [SYM_W-1:0] rdata
);

  logic [SYM_W-1:0] mem [MAX_TEXT];
  logic [SYM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mwc_seq.sv
module mwc_seq import mwc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  mwc_in_if.sink           in_ch,
  mwc_out_if.source        out_ch,
  output cnt_req_t         cnt_req,
  input  cnt_pair_t        cnt_rdata,
  output txt_req_t         txt_req,
  input  logic [SYM_W-1:0] txt_rdata,
  output stat_t            stat
);

  state_t             state_r, state_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               last_r, last_nxt;
  logic [PLEN_W-1:0]  plen_r, plen_nxt;
  logic [PLEN_W-1:0]  cov_r, cov_nxt;
  logic [TPOS_W-1:0]  wl_r, wl_nxt;
  logic [TPOS_W-1:0]  tpos_r, tpos_nxt;
  logic [START_W-1:0] bstart_r, bstart_nxt;
  logic [LEN_W-1:0]   blen_r, blen_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic               tstart_r, tstart_nxt;
  logic               drop_r, drop_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               ofound_r, ofound_nxt;
  logic [START_W-1:0] ostart_r, ostart_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic               oovf_r, oovf_nxt;
  logic [CNT_W-1:0]   have_inc;
  logic [LEN_W-1:0]   win_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      plen_r   <= '0;
      cov_r    <= '0;
      wl_r     <= '0;
      tpos_r   <= '0;
      bvalid_r <= 1'b0;
      tstart_r <= 1'b0;
      drop_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      plen_r   <= plen_nxt;
      cov_r    <= cov_nxt;
      wl_r     <= wl_nxt;
      tpos_r   <= tpos_nxt;
      bvalid_r <= bvalid_nxt;
      tstart_r <= tstart_nxt;
      drop_r   <= drop_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r    <= sym_nxt;
    last_r   <= last_nxt;
    bstart_r <= bstart_nxt;
    blen_r   <= blen_nxt;
    ofound_r <= ofound_nxt;
    ostart_r <= ostart_nxt;
    olen_r   <= olen_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign have_inc = cnt_rdata.have + CNT_W'(1);
  assign win_len  = LEN_W'(tpos_r - wl_r);

  always_comb begin
    state_nxt  = state_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    plen_nxt   = plen_r;
    cov_nxt    = cov_r;
    wl_nxt     = wl_r;
    tpos_nxt   = tpos_r;
    bstart_nxt = bstart_r;
    blen_nxt   = blen_r;
    bvalid_nxt = bvalid_r;
    tstart_nxt = tstart_r;
    drop_nxt   = drop_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ofound_nxt = ofound_r;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    oovf_nxt   = oovf_r;
    in_ch.ready = 1'b0;
    cnt_req     = '0;
    txt_req     = '0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          sym_nxt  = in_ch.symbol;
          last_nxt = in_ch.last;
          state_nxt = in_ch.last ? ST_DONE : ST_IDLE;
          if (!in_ch.mode) begin
            if (!tstart_r) begin
              if (plen_r >= PLEN_W'(MAX_PATTERN)) begin
                drop_nxt = 1'b1;
              end else begin
                cnt_req.rd_en   = 1'b1;
                cnt_req.rd_addr = in_ch.symbol;
                state_nxt       = ST_PAT_UPD;
              end
            end
          end else begin
            tstart_nxt = 1'b1;
            if (tpos_r >= TPOS_W'(MAX_TEXT)) begin
              drop_nxt = 1'b1;
            end else begin
              txt_req.wr_en   = 1'b1;
              txt_req.wr_addr = tpos_r[TADDR_W-1:0];
              txt_req.wr_data = in_ch.symbol;
              cnt_req.rd_en   = 1'b1;
              cnt_req.rd_addr = in_ch.symbol;
              tpos_nxt        = tpos_r + TPOS_W'(1);
              state_nxt       = ST_TXT_UPD;
            end
          end
        end
      end
      ST_PAT_UPD: begin
        cnt_req.wr_en        = 1'b1;
        cnt_req.wr_addr      = sym_r;
        cnt_req.wr_data.need = cnt_rdata.need + CNT_W'(1);
        cnt_req.wr_data.have = cnt_rdata.have;
        plen_nxt             = plen_r + PLEN_W'(1);
        state_nxt            = last_r ? ST_DONE : ST_IDLE;
      end
      ST_TXT_UPD: begin
        cnt_req.wr_en        = 1'b1;
        cnt_req.wr_addr      = sym_r;
        cnt_req.wr_data.need = cnt_rdata.need;
        cnt_req.wr_data.have = have_inc;
        if (have_inc <= cnt_rdata.need) begin
          cov_nxt = cov_r + PLEN_W'(1);
        end
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (plen_r != '0 && cov_r == plen_r && wl_r < tpos_r) begin
          if (!bvalid_r || win_len < blen_r) begin
            bvalid_nxt = 1'b1;
            bstart_nxt = wl_r[START_W-1:0];
            blen_nxt   = win_len;
          end
          txt_req.rd_en   = 1'b1;
          txt_req.rd_addr = wl_r[TADDR_W-1:0];
          state_nxt       = ST_OUT_SYM;
        end else begin
          state_nxt = last_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_OUT_SYM: begin
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = txt_rdata;
        sym_nxt         = txt_rdata;
        state_nxt       = ST_OUT_UPD;
      end
      ST_OUT_UPD: begin
        cnt_req.wr_en        = 1'b1;
        cnt_req.wr_addr      = sym_r;
        cnt_req.wr_data.need = cnt_rdata.need;
        cnt_req.wr_data.have = (cnt_rdata.have != '0) ? cnt_rdata.have - CNT_W'(1)
                                                      : cnt_rdata.have;
        if (cnt_rdata.have <= cnt_rdata.need) begin
          cov_nxt = cov_r - PLEN_W'(1);
        end
        wl_nxt    = wl_r + TPOS_W'(1);
        state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt    = 1'b1;
          ofound_nxt    = bvalid_r;
          ostart_nxt    = bvalid_r ? bstart_r : '0;
          olen_nxt      = bvalid_r ? blen_r : '0;
          oovf_nxt      = drop_r;
          cnt_req.clear = 1'b1;
          plen_nxt      = '0;
          cov_nxt       = '0;
          wl_nxt        = '0;
          tpos_nxt      = '0;
          bvalid_nxt    = 1'b0;
          tstart_nxt    = 1'b0;
          drop_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.found     = ofound_r;
  assign out_ch.start_res = ostart_r;
  assign out_ch.length    = olen_r;
  assign out_ch.overflow  = oovf_r;

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.plen = plen_r;
  assign stat.cov  = cov_r;
  assign stat.wl   = wl_r;
  assign stat.tpos = tpos_r;

endmodule
